FILE: design/lfpd_pkg.sv
// shared constants, types and register codes for the line follow pid drive
// no dependencies; every design file imports this package
package lfpd_pkg;

  localparam int WINDOW     = 10;
  localparam int POS_W      = 13;
  localparam int ERR_W      = 15;
  localparam int MAG_W      = 14;
  localparam int DIFF_W     = 16;
  localparam int ESUM_W     = 18;
  localparam int MSUM_W     = 17;
  localparam int DUTY_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int Q_SHIFT    = 20;

  typedef logic        [POS_W-1:0]  pos_t;
  typedef logic signed [ERR_W-1:0]  err_t;
  typedef logic        [MAG_W-1:0]  mag_t;
  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [ESUM_W-1:0] esum_t;
  typedef logic        [MSUM_W-1:0] msum_t;
  typedef logic        [DUTY_W-1:0] duty_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP           = 3'd0,
    REG_KD           = 3'd1,
    REG_KI_Q20       = 3'd2,
    REG_BASE_SPEED   = 3'd3,
    REG_TURN_SPEED   = 3'd4,
    REG_SLOW_GAIN    = 3'd5,
    REG_LINE_CENTER  = 3'd6,
    REG_POSITION_MAX = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_TRACK     = 2'd0,
    KIND_SPIN_ZERO = 2'd1,
    KIND_SPIN_FULL = 2'd2
  } kind_t;

  // window state seen by the pid pipeline
  typedef struct packed {
    esum_t esum;
    msum_t msum;
    err_t  prev_err;
  } win_state_t;

endpackage

FILE: design/line_follow_pid_drive_top.sv
// line follow pid drive: error window, pid correction, dual motor duty split
// uses lfpd_pkg and lfpd_window (which holds the row of lfpd_cell)
//
//  channel  | ports                                      | direction
//  ---------+--------------------------------------------+----------
//  input    | in_valid, in_ready, in_position            | in
//  result   | out_valid, out_ready, out_*_duty, out_sat. | out
//  config   | cfg_we, cfg_index, cfg_wdata               | in
//
// one transfer in per clock unless a stall holds it, one result per transfer;
// after the accept stage come multiply, scale and clamp, drive mix
// the window shifts at the input transfer, so the next sample may follow at once
// synchronous active-low reset clears the window, sums and config to defaults
// each stage holds while the one after it is full and stalled; bubbles absorb
module line_follow_pid_drive_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  lfpd_pkg::pos_t                       in_position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output lfpd_pkg::duty_t                      out_right_rev_duty,
  output lfpd_pkg::duty_t                      out_right_fwd_duty,
  output lfpd_pkg::duty_t                      out_left_rev_duty,
  output lfpd_pkg::duty_t                      out_left_fwd_duty,
  output logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import lfpd_pkg::*;

  typedef logic signed [27:0] drive_t;

  // config registers
  logic [7:0]  kp_r, kd_r, base_speed_r, turn_speed_r, slow_gain_r;
  logic [15:0] ki_q20_r;
  pos_t        line_center_r, position_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r           <= 8'd7;
      kd_r           <= 8'd40;
      ki_q20_r       <= 16'd1049;
      base_speed_r   <= 8'd200;
      turn_speed_r   <= 8'd230;
      slow_gain_r    <= 8'd0;
      line_center_r  <= 13'd2500;
      position_max_r <= 13'd5000;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KP:           kp_r           <= cfg_wdata[7:0];
        REG_KD:           kd_r           <= cfg_wdata[7:0];
        REG_KI_Q20:       ki_q20_r       <= cfg_wdata;
        REG_BASE_SPEED:   base_speed_r   <= cfg_wdata[7:0];
        REG_TURN_SPEED:   turn_speed_r   <= cfg_wdata[7:0];
        REG_SLOW_GAIN:    slow_gain_r    <= cfg_wdata[7:0];
        REG_LINE_CENTER:  line_center_r  <= cfg_wdata[POS_W-1:0];
        REG_POSITION_MAX: position_max_r <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic out_valid_r, s1_v_r, s2_v_r, s3_v_r;
  logic out_adv, s3_rdy, s2_rdy, s1_rdy, in_xfer;

  assign out_adv = !out_valid_r || out_ready;
  assign s3_rdy  = !s3_v_r || out_adv;
  assign s2_rdy  = !s2_v_r || s3_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;
  assign in_xfer  = in_valid && s1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy)  s1_v_r      <= in_valid;
      if (s2_rdy)  s2_v_r      <= s1_v_r;
      if (s3_rdy)  s3_v_r      <= s2_v_r;
      if (out_adv) out_valid_r <= s3_v_r;
    end
  end

  // accept stage: classify, error, window shift
  kind_t      kind_in;
  err_t       err_in;
  mag_t       mag_in;
  diff_t      diff_in;
  win_state_t win;
  logic       win_upd;

  always_comb begin
    if (in_position == '0)                 kind_in = KIND_SPIN_ZERO;
    else if (in_position == position_max_r) kind_in = KIND_SPIN_FULL;
    else                                   kind_in = KIND_TRACK;
    err_in  = $signed({2'b00, line_center_r}) - $signed({2'b00, in_position});
    mag_in  = err_in[ERR_W-1] ? mag_t'(-err_in) : mag_t'(err_in);
    diff_in = diff_t'(err_in) - diff_t'(win.prev_err);
  end

  assign win_upd = in_xfer && (kind_in == KIND_TRACK);

  lfpd_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .upd_i   (win_upd),
    .err_i   (err_in),
    .mag_i   (mag_in),
    .state_o (win)
  );

  kind_t s1_kind_r;
  err_t  s1_err_r;
  diff_t s1_diff_r;

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_kind_r <= kind_in;
      s1_err_r  <= err_in;
      s1_diff_r <= diff_in;
    end
  end

  // multiply stage; the window sums already include the item held in stage 1
  logic signed [23:0] kp_e;
  logic signed [24:0] kd_d;
  logic signed [34:0] ki_s;
  logic        [24:0] slow_p;

  always_comb begin
    kp_e   = $signed({1'b0, kp_r}) * s1_err_r;
    kd_d   = $signed({1'b0, kd_r}) * s1_diff_r;
    ki_s   = $signed({1'b0, ki_q20_r}) * win.esum;
    slow_p = slow_gain_r * win.msum;
  end

  kind_t              s2_kind_r;
  logic signed [23:0] s2_kp_e_r;
  logic signed [24:0] s2_kd_d_r;
  logic signed [34:0] s2_ki_s_r;
  logic        [24:0] s2_slow_r;

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_kind_r <= s1_kind_r;
      s2_kp_e_r <= kp_e;
      s2_kd_d_r <= kd_d;
      s2_ki_s_r <= ki_s;
      s2_slow_r <= slow_p;
    end
  end

  // scale stage: floor by 2^20 then fix up to truncate toward zero, clamp
  logic signed [25:0] pd;
  logic signed [26:0] q_floor, q_trunc, base_q;
  logic signed [8:0]  p_clamp;

  always_comb begin
    pd      = 26'(s2_kp_e_r) + 26'(s2_kd_d_r);
    q_floor = 27'(pd) + 27'($signed(s2_ki_s_r[34:Q_SHIFT]));
    q_trunc = q_floor + 27'(q_floor[26] && (|s2_ki_s_r[Q_SHIFT-1:0]));
    base_q  = $signed({19'b0, base_speed_r});
    if (q_trunc > base_q)       p_clamp = 9'(base_q);
    else if (q_trunc < -base_q) p_clamp = 9'(-base_q);
    else                        p_clamp = q_trunc[8:0];
  end

  kind_t             s3_kind_r;
  logic signed [8:0] s3_p_r;
  logic       [24:0] s3_slow_r;

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_kind_r <= s2_kind_r;
      s3_p_r    <= p_clamp;
      s3_slow_r <= s2_slow_r;
    end
  end

  // drive mix stage
  drive_t base_x, slow_x, p_x, turn_x, left_x, right_x;
  logic   sat_left, sat_right;
  logic signed [8:0] left_c, right_c, left_n, right_n;

  always_comb begin
    base_x = $signed({20'b0, base_speed_r});
    turn_x = $signed({20'b0, turn_speed_r});
    slow_x = $signed({3'b0, s3_slow_r});
    p_x    = drive_t'(s3_p_r);
    unique case (s3_kind_r)
      KIND_SPIN_ZERO: begin
        left_x  = -turn_x;
        right_x = turn_x;
      end
      KIND_SPIN_FULL: begin
        left_x  = turn_x;
        right_x = -turn_x;
      end
      KIND_TRACK: begin
        if (s3_p_r > 9'sd0) begin
          left_x  = base_x - slow_x;
          right_x = base_x - p_x - slow_x;
        end else begin
          left_x  = base_x + p_x - slow_x;
          right_x = base_x - slow_x;
        end
      end
      default: begin
        left_x  = '0;
        right_x = '0;
      end
    endcase
    sat_left  = (left_x > 28'sd255) || (left_x < -28'sd255);
    sat_right = (right_x > 28'sd255) || (right_x < -28'sd255);
    if (left_x > 28'sd255)       left_c = 9'sd255;
    else if (left_x < -28'sd255) left_c = -9'sd255;
    else                         left_c = left_x[8:0];
    if (right_x > 28'sd255)       right_c = 9'sd255;
    else if (right_x < -28'sd255) right_c = -9'sd255;
    else                          right_c = right_x[8:0];
    left_n  = -left_c;
    right_n = -right_c;
  end

  duty_t right_rev_r, right_fwd_r, left_rev_r, left_fwd_r;
  logic  sat_out_r;

  always_ff @(posedge clk) begin
    if (out_adv) begin
      right_rev_r <= right_c[8] ? right_n[7:0] : '0;
      right_fwd_r <= right_c[8] ? '0 : right_c[7:0];
      left_rev_r  <= left_c[8] ? left_n[7:0] : '0;
      left_fwd_r  <= left_c[8] ? '0 : left_c[7:0];
      sat_out_r   <= sat_left || sat_right;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_right_rev_duty = right_rev_r;
  assign out_right_fwd_duty = right_fwd_r;
  assign out_left_rev_duty  = left_rev_r;
  assign out_left_fwd_duty  = left_fwd_r;
  assign out_saturated      = sat_out_r;

  // a zero-position spin transfer leaves the window state untouched
  a_spin_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_position == '0) |=> $stable(win))
    else $error("window state changed on a spin transfer");

  // with the result register empty every stage can take data
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // a motor never gets both forward and reverse duty
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_right_rev_duty == '0 || out_right_fwd_duty == '0) &&
                   (out_left_rev_duty == '0 || out_left_fwd_duty == '0)))
    else $error("both directions driven on one motor");

endmodule

FILE: design/lfpd_cell.sv
// one window cell: holds one stored error and its magnitude
// passes them to the next cell on every window shift; uses lfpd_pkg
module lfpd_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_i,
  input  lfpd_pkg::err_t err_i,
  input  lfpd_pkg::mag_t mag_i,
  output lfpd_pkg::err_t err_o,
  output lfpd_pkg::mag_t mag_o
);
  import lfpd_pkg::*;

  err_t err_r;
  mag_t mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= '0;
      mag_r <= '0;
    end else if (shift_i) begin
      err_r <= err_i;
      mag_r <= mag_i;
    end
  end

  assign err_o = err_r;
  assign mag_o = mag_r;

endmodule

FILE: design/lfpd_window.sv
// sliding window of errors: a row of lfpd_cell plus the running sums
// and the previous error; uses lfpd_pkg and lfpd_cell
module lfpd_window (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                upd_i,
  input  lfpd_pkg::err_t      err_i,
  input  lfpd_pkg::mag_t      mag_i,
  output lfpd_pkg::win_state_t state_o
);
  import lfpd_pkg::*;

  err_t  err_chain [WINDOW+1];
  mag_t  mag_chain [WINDOW+1];
  esum_t esum_r, esum_nxt;
  msum_t msum_r, msum_nxt;
  err_t  prev_r;

  assign err_chain[0] = err_i;
  assign mag_chain[0] = mag_i;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    lfpd_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_i (upd_i),
      .err_i   (err_chain[i]),
      .mag_i   (mag_chain[i]),
      .err_o   (err_chain[i+1]),
      .mag_o   (mag_chain[i+1])
    );
  end

  // the last cell holds the entry that leaves the window on this shift
  assign esum_nxt = esum_r + esum_t'(err_i) - esum_t'(err_chain[WINDOW]);
  assign msum_nxt = msum_r + msum_t'(mag_i) - msum_t'(mag_chain[WINDOW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esum_r <= '0;
      msum_r <= '0;
      prev_r <= '0;
    end else if (upd_i) begin
      esum_r <= esum_nxt;
      msum_r <= msum_nxt;
      prev_r <= err_i;
    end
  end

  assign state_o = '{esum: esum_r, msum: msum_r, prev_err: prev_r};

endmodule

FILE: bench/tb.sv
// testbench for line_follow_pid_drive_top: directed table, then random phases
// predicts untyped results in its own model of the window and pid mix
// depends on lfpd_pkg and the design under bench test
module tb;
  import lfpd_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 210;

  typedef struct packed {
    duty_t right_rev;
    duty_t right_fwd;
    duty_t left_rev;
    duty_t left_fwd;
    logic  sat;
  } drive_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    cfg_reg_t  reg_idx;
    logic [15:0] data;
    pos_t      pos;
    logic      typed;
    drive_t    want;
  } stim_row_t;

  localparam int N_ROWS = 37;

  logic  clk;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  pos_t  in_position = '0;
  logic  out_valid;
  logic  out_ready = 1'b1;
  duty_t out_right_rev_duty;
  duty_t out_right_fwd_duty;
  duty_t out_left_rev_duty;
  duty_t out_left_fwd_duty;
  logic  out_saturated;
  logic  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // model copy of the configuration, reset values
  logic [7:0]  cfg_kp     = 8'd7;
  logic [7:0]  cfg_kd     = 8'd40;
  logic [15:0] cfg_ki     = 16'd1049;
  logic [7:0]  cfg_base   = 8'd200;
  logic [7:0]  cfg_turn   = 8'd230;
  logic [7:0]  cfg_slow   = 8'd0;
  pos_t        cfg_center = 13'd2500;
  pos_t        cfg_pmax   = 13'd5000;

  // model copy of the error window
  err_t  err_win [WINDOW] = '{default: '0};
  mag_t  mag_win [WINDOW] = '{default: '0};
  esum_t err_total  = '0;
  msum_t mag_total  = '0;
  int    win_slot   = 0;
  err_t  last_err   = '0;

  drive_t expected_duties [$];
  int     err_count   = 0;
  int     cycle_count = 0;
  int     stall_left  = 0;
  bit     idle_on     = 1'b1;
  int     walk        = 2500;

  stim_row_t stim_tab [N_ROWS] = '{
    // reset defaults: both spins and a centered sample on clean state
    '{ROW_ITEM, REG_KP, 16'd0, 13'd0,    1'b1, '{8'd0,   8'd230, 8'd230, 8'd0,   1'b0}},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd5000, 1'b1, '{8'd230, 8'd0,   8'd0,   8'd230, 1'b0}},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd2500, 1'b1, '{8'd0,   8'd200, 8'd0,   8'd200, 1'b0}},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd8191, 1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd1,    1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd4999, 1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd5001, 1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd2499, 1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd2501, 1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd4096, 1'b0, '0},
    // full scale at zero: the zero spin wins
    '{ROW_CFG,  REG_POSITION_MAX, 16'd0, 13'd0, 1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd0,    1'b1, '{8'd0,   8'd230, 8'd230, 8'd0,   1'b0}},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd3000, 1'b0, '0},
    // every register at its top value
    '{ROW_CFG,  REG_KP,           16'h00FF, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_KD,           16'h00FF, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_KI_Q20,       16'hFFFF, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_BASE_SPEED,   16'h00FF, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_TURN_SPEED,   16'h00FF, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_SLOW_GAIN,    16'h00FF, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_LINE_CENTER,  16'h1FFF, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_POSITION_MAX, 16'h1FFF, 13'd0, 1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd8191, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd255, 1'b0}},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd0,    1'b1, '{8'd0,   8'd255, 8'd255, 8'd0,   1'b0}},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd1,    1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd4000, 1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd8190, 1'b0, '0},
    // every register at zero
    '{ROW_CFG,  REG_KP,           16'h0000, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_KD,           16'h0000, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_KI_Q20,       16'h0000, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_BASE_SPEED,   16'h0000, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_TURN_SPEED,   16'h0000, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_SLOW_GAIN,    16'h0000, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_LINE_CENTER,  16'h0000, 13'd0, 1'b0, '0},
    '{ROW_CFG,  REG_POSITION_MAX, 16'h0000, 13'd0, 1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd0,    1'b1, '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0}},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd8191, 1'b0, '0},
    '{ROW_ITEM, REG_KP, 16'd0, 13'd1,    1'b0, '0}
  };

  line_follow_pid_drive_top uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_right_rev_duty (out_right_rev_duty),
    .out_right_fwd_duty (out_right_fwd_duty),
    .out_left_rev_duty  (out_left_rev_duty),
    .out_left_fwd_duty  (out_left_fwd_duty),
    .out_saturated      (out_saturated),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // advances the window on tracking samples and mixes the two drives
  function automatic drive_t predict_drive(pos_t p);
    longint lft, rgt, e, mag, corr, slow, base;
    drive_t d;
    logic sat;
    sat = 1'b0;
    base = longint'(cfg_base);
    if (p == '0) begin
      lft = -longint'(cfg_turn);
      rgt = longint'(cfg_turn);
    end else if (p == cfg_pmax) begin
      lft = longint'(cfg_turn);
      rgt = -longint'(cfg_turn);
    end else begin
      e = longint'(cfg_center) - longint'(p);
      mag = (e < 0) ? -e : e;
      win_slot = (win_slot + 1) % WINDOW;
      err_total = esum_t'(longint'(err_total) + e - longint'(err_win[win_slot]));
      err_win[win_slot] = err_t'(e);
      mag_total = msum_t'(longint'(mag_total) + mag - longint'(mag_win[win_slot]));
      mag_win[win_slot] = mag_t'(mag);
      corr = (longint'(cfg_kp) * e + longint'(cfg_kd) * (e - longint'(last_err)))
             * (longint'(1) << Q_SHIFT) + longint'(cfg_ki) * longint'(err_total);
      // signed division truncates toward zero
      corr = corr / (longint'(1) << Q_SHIFT);
      if (corr > base) corr = base;
      else if (corr < -base) corr = -base;
      last_err = err_t'(e);
      slow = longint'(cfg_slow) * longint'(mag_total);
      if (corr > 0) begin
        lft = base - slow;
        rgt = base - corr - slow;
      end else begin
        lft = base + corr - slow;
        rgt = base - slow;
      end
    end
    if (lft > 255) begin lft = 255; sat = 1'b1; end
    if (lft < -255) begin lft = -255; sat = 1'b1; end
    if (rgt > 255) begin rgt = 255; sat = 1'b1; end
    if (rgt < -255) begin rgt = -255; sat = 1'b1; end
    d.right_rev = (rgt < 0) ? duty_t'(-rgt) : '0;
    d.right_fwd = (rgt < 0) ? '0 : duty_t'(rgt);
    d.left_rev  = (lft < 0) ? duty_t'(-lft) : '0;
    d.left_fwd  = (lft < 0) ? '0 : duty_t'(lft);
    d.sat       = sat;
    return d;
  endfunction

  function automatic logic [15:0] pick_value(int unsigned maxv);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 16'(maxv);
    return 16'($urandom_range(0, maxv));
  endfunction

  // mostly a wandering line near center, with spins and wild samples mixed in
  function automatic pos_t pick_position();
    int unsigned r;
    int span;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return cfg_pmax;
    if (r < 25) return pos_t'($urandom);
    if (r < 40) begin
      span = $urandom_range(0, 400);
      return pos_t'(int'(cfg_center) + int'($urandom_range(0, 2 * span)) - span);
    end
    walk = walk + int'($urandom_range(0, 200)) - 100;
    if (walk < 1) walk = 1;
    if (walk > 8191) walk = 8191;
    return pos_t'(walk);
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_KP:           cfg_kp     = data[7:0];
      REG_KD:           cfg_kd     = data[7:0];
      REG_KI_Q20:       cfg_ki     = data;
      REG_BASE_SPEED:   cfg_base   = data[7:0];
      REG_TURN_SPEED:   cfg_turn   = data[7:0];
      REG_SLOW_GAIN:    cfg_slow   = data[7:0];
      REG_LINE_CENTER:  cfg_center = data[POS_W-1:0];
      REG_POSITION_MAX: cfg_pmax   = data[POS_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic shuffle_config();
    cfg_reg_t idx;
    int unsigned maxv;
    logic [15:0] v;
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        REG_KI_Q20:                        maxv = 16'hFFFF;
        REG_LINE_CENTER, REG_POSITION_MAX: maxv = 13'h1FFF;
        default:                           maxv = 8'hFF;
      endcase
      v = pick_value(maxv);
      if ((idx == REG_KP || idx == REG_KD) && $urandom_range(0, 1) == 1)
        v = 16'($urandom_range(0, 15));
      if (idx == REG_SLOW_GAIN && $urandom_range(0, 3) != 0)
        v = 16'($urandom_range(0, 2));
      // junk above the register width is dropped by the block
      if ($urandom_range(0, 3) == 0) v = v | (16'($urandom) & ~16'(maxv));
      write_reg(idx, v);
      idx = idx.next();
    end
  endtask

  task automatic send_position(pos_t p, logic typed, drive_t want);
    drive_t pred;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_position <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = predict_drive(p);
    expected_duties.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    drive_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_duties.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        err_count++;
      end else begin
        want = expected_duties.pop_front();
        check_field("right_rev_duty", want.right_rev, out_right_rev_duty);
        check_field("right_fwd_duty", want.right_fwd, out_right_fwd_duty);
        check_field("left_rev_duty",  want.left_rev,  out_left_rev_duty);
        check_field("left_fwd_duty",  want.left_fwd,  out_left_fwd_duty);
        check_field("saturated",      want.sat,       out_saturated);
      end
    end
  end

  // receiver stalls in random bursts while idle gaps are on
  always @(posedge clk) begin : ready_gen
    if (!rst_n || !idle_on) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_tab[i]) begin
      if (stim_tab[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(stim_tab[i].reg_idx, stim_tab[i].data);
      end else begin
        send_position(stim_tab[i].pos, stim_tab[i].typed, stim_tab[i].want);
      end
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      drain_results();
      shuffle_config();
      walk = int'(cfg_center);
      // one quiet phase in the middle and a quiet tail
      idle_on = (phase != 3) && (phase != N_PHASES - 1);
      repeat (PHASE_ITEMS) send_position(pick_position(), 1'b0, '0);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_duties.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
